// ===== rtl/lspd_pkg.sv =====
// Package for the long/short press detector: constants, register codes, types, helpers.
package lspd_pkg;

    // Fixed datapath sizes
    localparam int HW_BUTTONS       = 4;
    localparam int NUM_BUTTONS_DEF  = 4;
    localparam int TIME_W           = 5;
    localparam int COUNT_W          = 8;
    localparam int MASK_W           = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 5;
    localparam int TIME_SCALE       = 10;
    localparam int COUNT_MAX        = 255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME_B2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME_B3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ACT_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_ACT_MASK = 3'd5;

    // Configuration state handed to the button slices
    typedef struct packed {
        logic [HW_BUTTONS-1:0][TIME_W-1:0] long_time;
        logic [MASK_W-1:0]                 long_mask;
        logic [MASK_W-1:0]                 short_mask;
    } t_cfg;

    // Per-button control for one processed transaction
    typedef struct packed {
        logic step;   // transaction is processed this cycle
        logic tick;   // 1 = timer tick, 0 = level sample
        logic now;    // sampled level
        logic prev;   // level of the previous sample
    } t_btn_ctl;

    // Long time times ten, saturated to the countdown range
    function automatic logic [COUNT_W-1:0] scale_time(input logic [TIME_W-1:0] t);
        logic [COUNT_W:0] prod;
        prod = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
        scale_time = (prod > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                      : prod[COUNT_W-1:0];
    endfunction

endpackage

// ===== rtl/lspd_if.sv =====
// Channel interfaces of the press detector: input items, results, configuration writes.
interface lspd_item_if import lspd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [MASK_W-1:0] levels;

    modport source (output valid, output func, output levels, input ready);
    modport sink   (input valid, input func, input levels, output ready);
endinterface

interface lspd_result_if import lspd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] short_press;
    logic [MASK_W-1:0] long_press;

    modport source (output valid, output short_press, output long_press, input ready);
    modport sink   (input valid, input short_press, input long_press, output ready);
endinterface

interface lspd_cfg_if import lspd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lspd_cfg.sv =====
// Configuration register file of the press detector.
module lspd_cfg import lspd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lspd_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LONG_TIME_B0:   r_cfg.long_time[0] <= i_cfg.data[TIME_W-1:0];
                REG_LONG_TIME_B1:   r_cfg.long_time[1] <= i_cfg.data[TIME_W-1:0];
                REG_LONG_TIME_B2:   r_cfg.long_time[2] <= i_cfg.data[TIME_W-1:0];
                REG_LONG_TIME_B3:   r_cfg.long_time[3] <= i_cfg.data[TIME_W-1:0];
                REG_LONG_ACT_MASK:  r_cfg.long_mask    <= i_cfg.data[MASK_W-1:0];
                REG_SHORT_ACT_MASK: r_cfg.short_mask   <= i_cfg.data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/lspd_btn.sv =====
// One button slice: press countdown and release classification.
module lspd_btn import lspd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_btn_ctl          i_ctl,
    input  logic [TIME_W-1:0] i_long_time,
    input  logic              i_long_en,
    input  logic              i_short_en,
    output logic              o_short,
    output logic              o_long
);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               rise;
    logic               fall;

    assign rise = !i_ctl.tick && i_ctl.now && !i_ctl.prev;
    assign fall = !i_ctl.tick && !i_ctl.now && i_ctl.prev;

    // Release events, long wins when the countdown has expired
    assign o_long  = fall && i_long_en && (r_count == '0);
    assign o_short = fall && !o_long && i_short_en;

    // Countdown: load on press, decrement on tick
    always_comb begin
        n_count = r_count;
        if (i_ctl.step) begin
            if (i_ctl.tick) begin
                if (r_count != '0) begin
                    n_count = r_count - COUNT_W'(1);
                end
            end else if (rise) begin
                n_count = scale_time(i_long_time);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/long_short_press_detector.sv =====
// Long/short press detector for up to four buttons.
//
// Usage:
//   i_item carries one transaction per accepted handshake: func 0 samples
//   the button levels, func 1 is a timer tick. Every transaction yields one
//   result on o_result with the short_press and long_press event bits of
//   the buttons released by that sample (tick results are all zero).
//   i_cfg writes the long times (index 0..3) and the long/short action masks
//   (index 4, 5); it is always ready. The user must write it only while idle;
//   the block itself leaves this unchecked.
// Path: input register, then result register, which drives o_result.
//   Throughput: one transaction per cycle while o_result is taken.
// Stall: when o_result is held, the input register still takes one more
//   transaction; after that i_item.ready drops until the result is taken.
// Reset: countdowns, previous levels, configuration and valid flags clear to
//   zero; both channels come up empty and ready.
module long_short_press_detector import lspd_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lspd_item_if.sink      i_item,
    lspd_cfg_if.sink       i_cfg,
    lspd_result_if.source  o_result
);

    localparam int ActiveButtons = (NUM_BUTTONS > HW_BUTTONS) ? HW_BUTTONS : NUM_BUTTONS;
    localparam logic [MASK_W-1:0] UsedMask = MASK_W'((1 << ActiveButtons) - 1);

    t_cfg              cfg;
    logic              r_in_valid;
    logic              r_in_func;
    logic [MASK_W-1:0] r_in_levels;
    logic [MASK_W-1:0] r_prev;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_short;
    logic [MASK_W-1:0] r_long;
    logic              step;
    logic [MASK_W-1:0] now;
    logic [MASK_W-1:0] shorts;
    logic [MASK_W-1:0] longs;

    lspd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Handshake: stage advances when the result register is free or drained
    assign step         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || step;
    assign now          = r_in_levels & UsedMask;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_func   <= i_item.func;
            r_in_levels <= i_item.levels;
        end
    end

    // Button slices; unused buttons stay silent
    for (genvar g = 0; g < HW_BUTTONS; g++) begin : g_btn
        if (g < ActiveButtons) begin : g_on
            t_btn_ctl ctl;
            assign ctl.step = step;
            assign ctl.tick = r_in_func;
            assign ctl.now  = now[g];
            assign ctl.prev = r_prev[g];

            lspd_btn u_btn (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_long_time (cfg.long_time[g]),
                .i_long_en   (cfg.long_mask[g]),
                .i_short_en  (cfg.short_mask[g]),
                .o_short     (shorts[g]),
                .o_long      (longs[g])
            );
        end else begin : g_off
            assign shorts[g] = 1'b0;
            assign longs[g]  = 1'b0;
        end
    end

    // Previous levels, updated by samples only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (step && !r_in_func) begin
            r_prev <= now;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_short <= shorts;
            r_long  <= longs;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.short_press = r_short;
    assign o_result.long_press  = r_long;

endmodule

// ===== tb/long_short_press_detector_test.sv =====
// Self-checking testbench for the long/short press detector: directed and random press sequences.
import lspd_pkg::*;

// Item kinds on the input channel
typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
} press_func_e;

// Register indexes with no register behind them; writes must be dropped
localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

typedef struct packed {
    logic [MASK_W-1:0] short_press;
    logic [MASK_W-1:0] long_press;
} press_events_t;

// Tracks button state and configuration, predicts the events of every transaction
class press_scoreboard;
    logic [TIME_W-1:0]  hold_time [HW_BUTTONS];
    logic [MASK_W-1:0]  long_en;
    logic [MASK_W-1:0]  short_en;
    logic [MASK_W-1:0]  last_levels;
    logic [COUNT_W-1:0] ticks_left [HW_BUTTONS];
    press_events_t      pending_events [$];
    int                 mismatches;

    function new();
        int b;
        for (b = 0; b < HW_BUTTONS; b++) begin
            hold_time[b]  = '0;
            ticks_left[b] = '0;
        end
        long_en     = '0;
        short_en    = '0;
        last_levels = '0;
        mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx <= REG_LONG_TIME_B3) begin
            hold_time[idx - REG_LONG_TIME_B0] = data[TIME_W-1:0];
        end else if (idx == REG_LONG_ACT_MASK) begin
            long_en = data[MASK_W-1:0];
        end else if (idx == REG_SHORT_ACT_MASK) begin
            short_en = data[MASK_W-1:0];
        end
    endfunction

    // Accepted input transaction: update state and queue the events it produces
    function void note_item(press_func_e func, logic [MASK_W-1:0] levels);
        int                b;
        int                nbtn;
        int                scaled;
        logic [MASK_W-1:0] now;
        logic [MASK_W-1:0] rise;
        logic [MASK_W-1:0] fall;
        press_events_t     ev;
        nbtn = (NUM_BUTTONS_DEF > HW_BUTTONS) ? HW_BUTTONS : NUM_BUTTONS_DEF;
        ev   = '0;
        if (func == FUNC_TICK) begin
            for (b = 0; b < nbtn; b++) begin
                if (ticks_left[b] != 0) ticks_left[b]--;
            end
        end else begin
            now  = levels & MASK_W'((1 << nbtn) - 1);
            rise = now & ~last_levels;
            fall = last_levels & ~now;
            for (b = 0; b < nbtn; b++) begin
                if (rise[b]) begin
                    // load time x10, saturated to the counter range
                    scaled        = int'(hold_time[b]) * TIME_SCALE;
                    ticks_left[b] = (scaled > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                         : COUNT_W'(scaled);
                end else if (fall[b]) begin
                    if (long_en[b] && ticks_left[b] == 0) ev.long_press[b] = 1'b1;
                    else if (short_en[b]) ev.short_press[b] = 1'b1;
                end
            end
            last_levels = now;
        end
        pending_events.push_back(ev);
    endfunction

    // Accepted result transaction: compare with the oldest prediction
    function void check_result(logic [MASK_W-1:0] short_press, logic [MASK_W-1:0] long_press);
        press_events_t want;
        if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: short=%h long=%h", short_press, long_press);
            return;
        end
        want = pending_events.pop_front();
        if (want.short_press !== short_press || want.long_press !== long_press) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected short=%h long=%h, got short=%h long=%h",
                         want.short_press, want.long_press, short_press, long_press);
        end
    endfunction
endclass

module long_short_press_detector_test;

    localparam int IDLE_LIMIT      = 1000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lspd_item_if   item_ch ();
    lspd_cfg_if    cfg_ch ();
    lspd_result_if res_ch ();

    long_short_press_detector DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    press_scoreboard   presses;
    bit                tx_gaps_on;
    bit                rx_stall_on;
    bit                hold_off_req;
    logic [MASK_W-1:0] held_levels;   // levels last driven on a sample
    int                idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    // Mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random back-pressure plus one requested long hold-off
    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else if (stall_left == 0 && rx_stall_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            presses.check_result(res_ch.short_press, res_ch.long_press);
    end

    // Watchdog: no transaction on any channel for too long
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[long_short_press_detector] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(press_func_e f, logic [MASK_W-1:0] lv);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            item_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        item_ch.valid  = 1'b1;
        item_ch.func   = f;
        item_ch.levels = lv;
        do @(posedge i_clk); while (!item_ch.ready);
        presses.note_item(f, lv);
    endtask

    task automatic press_sample(logic [MASK_W-1:0] lv);
        send_item(FUNC_SAMPLE, lv);
        held_levels = lv;
    endtask

    // Levels on a tick are don't-care, so drive noise there
    task automatic tick();
        send_item(FUNC_TICK, MASK_W'($urandom));
    endtask

    // Stop offering and let every pending result come out
    task automatic drain();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (presses.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        presses.write_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Unused top data bit on the masks is randomized; it must be ignored
    task automatic set_config(logic [HW_BUTTONS-1:0][TIME_W-1:0] times,
                              logic [MASK_W-1:0] lmask, logic [MASK_W-1:0] smask);
        int b;
        for (b = 0; b < HW_BUTTONS; b++)
            write_reg(CFG_IDX_W'(REG_LONG_TIME_B0 + b), CFG_DATA_W'(times[b]));
        write_reg(REG_LONG_ACT_MASK, {1'($urandom_range(0, 1)), lmask});
        write_reg(REG_SHORT_ACT_MASK, {1'($urandom_range(0, 1)), smask});
    endtask

    // Mostly press/release of single buttons with tick runs in between
    task automatic random_presses(int count);
        int done;
        int run;
        int r;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                repeat (run) tick();
                done += run;
            end else if (r < 9) begin
                press_sample(held_levels ^ MASK_W'(1 << $urandom_range(0, MASK_W - 1)));
                done++;
            end else begin
                press_sample(MASK_W'($urandom));
                done++;
            end
        end
    endtask

    initial begin : stimulus
        int                               ph;
        int                               b;
        logic [HW_BUTTONS-1:0][TIME_W-1:0] times;
        logic [MASK_W-1:0]                lmask;
        logic [MASK_W-1:0]                smask;
        presses        = new();
        item_ch.valid  = 1'b0;
        item_ch.func   = FUNC_SAMPLE;
        item_ch.levels = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_LONG_TIME_B0;
        cfg_ch.data    = '0;
        tx_gaps_on     = 1'b0;
        rx_stall_on    = 1'b0;
        hold_off_req   = 1'b0;
        held_levels    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset configuration: no action enabled, releases stay silent
        press_sample(4'hF);
        tick();
        press_sample(4'h0);
        drain();

        // Long times zero, one, top of range and above range (saturates)
        set_config({5'd31, 5'd25, 5'd1, 5'd0}, 4'hF, 4'hF);
        write_reg(REG_SPARE_A, 5'h1F);
        write_reg(REG_SPARE_B, 5'h1F);
        press_sample(4'hF);
        repeat (10) tick();
        press_sample(4'h0);
        press_sample(4'h5);
        tick();
        press_sample(4'hA);
        press_sample(4'h0);
        drain();

        // Mixed masks: long only, short only, both, neither
        set_config({5'd2, 5'd0, 5'd3, 5'd0}, 4'b0101, 4'b0011);
        press_sample(4'hF);
        press_sample(4'h0);
        tick();

        // Random phases, each with its own configuration and idling mix
        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            for (b = 0; b < HW_BUTTONS; b++) begin
                if (ph == 0) times[b] = '0;
                else if (ph == 1) times[b] = '1;
                else if ($urandom_range(0, 7) == 0) times[b] = TIME_W'($urandom_range(0, 31));
                else times[b] = TIME_W'($urandom_range(0, 3));
            end
            lmask = (ph == 0 || ph == 2) ? 4'hF : (ph == 1) ? 4'h0 : MASK_W'($urandom);
            smask = (ph == 1 || ph == 2) ? 4'hF : (ph == 0) ? 4'h0 : MASK_W'($urandom);
            set_config(times, lmask, smask);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom));
            tx_gaps_on  = (ph % 3) != 1;
            rx_stall_on = (ph % 3) != 2;
            if (ph == 3) begin
                // keep offering while the result side holds off
                tx_gaps_on   = 1'b0;
                hold_off_req = 1'b1;
            end
            random_presses(ITEMS_PER_PHASE);
        end
        drain();

        if (presses.mismatches == 0 && presses.pending_events.size() == 0) begin
            $display("[long_short_press_detector] OK");
        end else begin
            $display("[long_short_press_detector] ERROR");
        end
        $finish;
    end

endmodule
